>>> rtl/ndp_pkg.sv
// ----------------------------------------------------------------------------
// ndp_pkg
// Shared types and constants for the neuron dot product block.
// ----------------------------------------------------------------------------
package ndp_pkg;

  localparam int unsigned FIELD_WIDTH = 16;
  localparam int unsigned PROD_WIDTH  = 32;
  localparam int unsigned OUT_WIDTH   = 9;
  localparam int unsigned RES_WIDTH   = 8;
  localparam int unsigned LOG_KNEE    = 100;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_ROUND,
    ST_LOG,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic load_mag;
    logic step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic log_more;
    logic out_free;
  } status_t;

endpackage

>>> rtl/ndp_in_if.sv
// ----------------------------------------------------------------------------
// ndp_in_if
// Synapse request channel: weight, input activation and last flag.
// ----------------------------------------------------------------------------
interface ndp_in_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [ndp_pkg::FIELD_WIDTH-1:0]     weight;
  logic signed [ndp_pkg::FIELD_WIDTH-1:0]     in_activation;
  logic                                       last;

  modport source (output valid, output weight, output in_activation, output last,
                  input ready);
  modport sink   (input valid, input weight, input in_activation, input last,
                  output ready);
endinterface

>>> rtl/ndp_out_if.sv
// ----------------------------------------------------------------------------
// ndp_out_if
// Result request channel: output activation of the neuron.
// ----------------------------------------------------------------------------
interface ndp_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [ndp_pkg::OUT_WIDTH-1:0]   out_activation;

  modport source (output valid, output out_activation, input ready);
  modport sink   (input valid, input out_activation, output ready);
endinterface

>>> rtl/ndp_ctrl.sv
// ----------------------------------------------------------------------------
// ndp_ctrl
// Sequencer: accumulate, round, log-compress and hand over the result.
// ----------------------------------------------------------------------------
module ndp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_last,
  output logic             in_ready,
  input  ndp_pkg::status_t status,
  output ndp_pkg::cmd_t    cmd
);

  ndp_pkg::state_t state_r;
  ndp_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ndp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ndp_pkg::ST_IDLE: begin
        if (in_valid && in_last) begin
          state_nxt = ndp_pkg::ST_ACC;
        end
      end
      ndp_pkg::ST_ACC:   state_nxt = ndp_pkg::ST_ROUND;
      ndp_pkg::ST_ROUND: state_nxt = ndp_pkg::ST_LOG;
      ndp_pkg::ST_LOG: begin
        if (!status.log_more) begin
          state_nxt = ndp_pkg::ST_EMIT;
        end
      end
      ndp_pkg::ST_EMIT: begin
        if (status.out_free) begin
          state_nxt = ndp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ndp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    unique case (state_r)
      ndp_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ndp_pkg::ST_ACC:   ;
      ndp_pkg::ST_ROUND: cmd.load_mag = 1'b1;
      ndp_pkg::ST_LOG:   cmd.step     = status.log_more;
      ndp_pkg::ST_EMIT:  cmd.emit     = status.out_free;
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_last_to_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ndp_pkg::ST_IDLE && in_valid && in_last) |=> state_r == ndp_pkg::ST_ACC)
    else $error("last request did not start the finish sequence");
  a_round_to_log: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_mag |=> state_r == ndp_pkg::ST_LOG)
    else $error("rounding not followed by log compression");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> status.out_free)
    else $error("result emitted into an occupied output register");
`endif

endmodule

>>> rtl/ndp_datapath.sv
// ----------------------------------------------------------------------------
// ndp_datapath
// Product register, accumulator, rounding and the halving log compressor.
// ----------------------------------------------------------------------------
module ndp_datapath #(
  parameter int unsigned WEIGHT_FRAC_BITS = 8,
  parameter int unsigned ACC_WIDTH        = 48
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  ndp_pkg::cmd_t                         cmd,
  output ndp_pkg::status_t                      status,
  input  logic signed [ndp_pkg::FIELD_WIDTH-1:0] weight,
  input  logic signed [ndp_pkg::FIELD_WIDTH-1:0] in_activation,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [ndp_pkg::OUT_WIDTH-1:0]  out_activation
);

  localparam int unsigned EXT_W = ACC_WIDTH + 1;
  localparam int unsigned MAG_W = EXT_W - WEIGHT_FRAC_BITS;
  localparam logic [EXT_W-1:0] HALF     = EXT_W'(1) << (WEIGHT_FRAC_BITS - 1);
  localparam logic [EXT_W-1:0] NEG_BIAS = HALF + (EXT_W'(1) << WEIGHT_FRAC_BITS);

  logic signed [ndp_pkg::PROD_WIDTH-1:0] prod_r;
  logic                                  prod_vld_r;
  logic signed [ACC_WIDTH-1:0]           acc_r;
  logic [MAG_W-1:0]                      shift_r;
  logic [ndp_pkg::RES_WIDTH-1:0]         res_r;
  logic                                  neg_r;
  logic                                  out_valid_r;
  logic signed [ndp_pkg::OUT_WIDTH-1:0]  out_act_r;

  logic [EXT_W-1:0] ext;
  logic [EXT_W-1:0] rnd_sum;
  logic [MAG_W-1:0] mag;
  logic             mag_small;

  always_comb begin
    ext       = {acc_r[ACC_WIDTH-1], acc_r};
    rnd_sum   = acc_r[ACC_WIDTH-1] ? (~ext + NEG_BIAS) : (ext + HALF);
    mag       = rnd_sum[EXT_W-1:WEIGHT_FRAC_BITS];
    mag_small = mag <= MAG_W'(ndp_pkg::LOG_KNEE);
  end

  assign status.log_more = shift_r[MAG_W-1:1] >= (MAG_W-1)'(ndp_pkg::LOG_KNEE);
  assign status.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r  <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      prod_vld_r <= cmd.accept;
      if (cmd.load_mag) begin
        acc_r <= '0;
      end else if (prod_vld_r) begin
        acc_r <= acc_r + ACC_WIDTH'(prod_r);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      prod_r <= weight * in_activation;
    end
    if (cmd.load_mag) begin
      shift_r <= mag;
      neg_r   <= acc_r[ACC_WIDTH-1];
      res_r   <= mag_small ? mag[ndp_pkg::RES_WIDTH-1:0]
                           : ndp_pkg::RES_WIDTH'(ndp_pkg::LOG_KNEE);
    end else if (cmd.step) begin
      shift_r <= shift_r >> 1;
      res_r   <= res_r + 1'b1;
    end
    if (cmd.emit) begin
      out_act_r <= neg_r ? -$signed({1'b0, res_r}) : $signed({1'b0, res_r});
    end
  end

  assign out_valid      = out_valid_r;
  assign out_activation = out_act_r;

`ifndef ASSERT_OFF
  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_mag |=> acc_r == '0)
    else $error("accumulator not cleared after rounding");
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r)
    else $error("emitted result not presented");
`endif

endmodule

>>> rtl/neuron_dot_product_log_limit.sv
// ----------------------------------------------------------------------------
// neuron_dot_product_log_limit
// Fixed point neuron multiply-accumulate with log-limited output activation.
// ----------------------------------------------------------------------------
// Each synapse request adds weight times input activation into an ACC_WIDTH
// accumulator; a request that is not last is taken every cycle. After a last
// request, ready stays low through ST_ACC, ST_ROUND, ST_LOG, where the log
// compressor applies its halvings (one per cycle, none for magnitudes up to
// 199), and ST_EMIT, which waits while the output register is occupied. The
// result sits in an output register, so the next neuron's requests are
// taken while it waits to be collected.
module neuron_dot_product_log_limit #(
  parameter int unsigned WEIGHT_FRAC_BITS = 8,
  parameter int unsigned ACC_WIDTH        = 48
) (
  input  logic      clk,
  input  logic      rst_n,
  ndp_in_if.sink    in_s,
  ndp_out_if.source out_m
);

  ndp_pkg::cmd_t    cmd;
  ndp_pkg::status_t status;

  ndp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_s.valid),
    .in_last  (in_s.last),
    .in_ready (in_s.ready),
    .status   (status),
    .cmd      (cmd)
  );

  ndp_datapath #(
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS),
    .ACC_WIDTH        (ACC_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .weight         (in_s.weight),
    .in_activation  (in_s.in_activation),
    .out_valid      (out_m.valid),
    .out_ready      (out_m.ready),
    .out_activation (out_m.out_activation)
  );

endmodule

>>> test/tb_neuron_dot_product_log_limit.sv
// ----------------------------------------------------------------------------
// tb_neuron_dot_product_log_limit
// Self-checking bench for the neuron multiply-accumulate with log limiting.
// ----------------------------------------------------------------------------
// Synapse requests go in through the input channel in bursts with random gaps.
// A scoreboard process keeps its own 48-bit sum, rounds and log-compresses it
// on each last request and queues the expected activation. Results are
// collected under a shifting stall pattern and compared in order. The tests
// cover rounding and knee edges, long chains of extreme products, a long
// output hold-off and a random run of neurons of mixed size and range.
// ----------------------------------------------------------------------------
module tb_neuron_dot_product_log_limit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FIELD_WIDTH   = ndp_pkg::FIELD_WIDTH;
  localparam int unsigned PROD_WIDTH    = ndp_pkg::PROD_WIDTH;
  localparam int unsigned OUT_WIDTH     = ndp_pkg::OUT_WIDTH;
  localparam int unsigned LOG_KNEE      = ndp_pkg::LOG_KNEE;

  localparam int unsigned FRAC_BITS     = 8;
  localparam int unsigned SUM_WIDTH     = 48;
  localparam int unsigned HALF_LSB      = 1 << (FRAC_BITS - 1);
  localparam int unsigned LSB_MINUS_ONE = (1 << FRAC_BITS) - 1;
  localparam int unsigned LARGE_COUNT   = 128;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned IDLE_LIMIT    = 4000;
  localparam int unsigned RANDOM_ITEMS  = 1800;

  typedef enum int {
    RANGE_SMALL,
    RANGE_MEDIUM,
    RANGE_FULL,
    RANGE_CORNER
  } value_range_t;

  logic clk;
  logic rst_n;

  ndp_in_if  in_if ();
  ndp_out_if out_if ();

  neuron_dot_product_log_limit #(
    .WEIGHT_FRAC_BITS (FRAC_BITS),
    .ACC_WIDTH        (SUM_WIDTH)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_if),
    .out_m (out_if)
  );

  logic [SUM_WIDTH-1:0]        neuron_sum;
  logic signed [OUT_WIDTH-1:0] expected_activations[$];

  int unsigned error_count;
  int unsigned requests_sent;
  int unsigned neurons_sent;
  int unsigned activations_checked;
  int unsigned idle_cycles;
  int unsigned burst_left;
  bit          gaps_enabled;
  bit          long_hold_request;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [OUT_WIDTH-1:0] limited_activation(
    input logic [SUM_WIDTH-1:0] sum
  );
    logic [SUM_WIDTH:0] mag;
    logic [SUM_WIDTH:0] halved;
    int unsigned        level;
    logic               negative;
    negative = sum[SUM_WIDTH-1];
    if (sum == '0) begin
      return '0;
    end
    if (!negative) begin
      mag = ({1'b0, sum} + HALF_LSB) >> FRAC_BITS;
    end else begin
      mag = ({1'b0, ~sum + 1'b1} + HALF_LSB + LSB_MINUS_ONE) >> FRAC_BITS;
    end
    if (mag > LOG_KNEE) begin
      level  = LOG_KNEE;
      halved = mag >> 1;
      while (halved >= LOG_KNEE) begin
        level++;
        halved = halved >> 1;
      end
    end else begin
      level = int'(mag);
    end
    return negative ? -OUT_WIDTH'(level) : OUT_WIDTH'(level);
  endfunction

  task automatic report_mismatch(input string what, input int expected_value,
                                 input int actual_value);
    $display("[%0t] mismatch: %s expected %0d got %0d", $realtime, what,
             expected_value, actual_value);
    error_count++;
  endtask

  // accumulate every accepted request, queue an activation on each last one
  always @(posedge clk) begin
    logic signed [PROD_WIDTH-1:0] product;
    if (!rst_n) begin
      neuron_sum <= '0;
    end else if (in_if.valid && in_if.ready) begin
      product = in_if.weight * in_if.in_activation;
      if (in_if.last) begin
        expected_activations.push_back(limited_activation(
          neuron_sum + {{(SUM_WIDTH-PROD_WIDTH){product[PROD_WIDTH-1]}}, product}));
        neuron_sum <= '0;
      end else begin
        neuron_sum <= neuron_sum + {{(SUM_WIDTH-PROD_WIDTH){product[PROD_WIDTH-1]}},
                                    product};
      end
    end
  end

  always @(posedge clk) begin
    logic signed [OUT_WIDTH-1:0] expected_value;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_activations.size() == 0) begin
        report_mismatch("unexpected out_activation", 0, out_if.out_activation);
      end else begin
        expected_value = expected_activations.pop_front();
        if (out_if.out_activation !== expected_value) begin
          report_mismatch("out_activation", expected_value, out_if.out_activation);
        end
      end
      activations_checked++;
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no request accepted for %0d cycles", IDLE_LIMIT);
      $display("tb_neuron_dot_product_log_limit: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: stall pattern changes at random; long hold on request
  initial begin
    int unsigned hold_left;
    int unsigned mode_left;
    int unsigned mode;
    hold_left = 0;
    mode_left = 0;
    mode      = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_request) begin
        long_hold_request = 1'b0;
        hold_left         = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= $urandom_range(0, 1);
          2: out_if.ready <= ($urandom_range(0, 3) == 0);
          default: out_if.ready <= mode_left[2];
        endcase
      end
    end
  end

  task automatic send_synapse(input logic signed [FIELD_WIDTH-1:0] weight,
                              input logic signed [FIELD_WIDTH-1:0] activation,
                              input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 20);
      gap = gaps_enabled ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_if.valid         <= 1'b1;
    in_if.weight        <= weight;
    in_if.in_activation <= activation;
    in_if.last          <= last;
    do @(posedge clk); while (!in_if.ready);
    requests_sent++;
    if (last) begin
      neurons_sent++;
    end
  endtask

  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (activations_checked < neurons_sent) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [FIELD_WIDTH-1:0] pick_value(
    input value_range_t range, input bit is_weight
  );
    case (range)
      RANGE_SMALL: begin
        return is_weight ? FIELD_WIDTH'(int'($urandom_range(0, 600)) - 300)
                         : FIELD_WIDTH'(int'($urandom_range(0, 240)) - 120);
      end
      RANGE_MEDIUM: begin
        return is_weight ? FIELD_WIDTH'(int'($urandom_range(0, 8192)) - 4096)
                         : FIELD_WIDTH'(int'($urandom_range(0, 1024)) - 512);
      end
      RANGE_CORNER: begin
        case ($urandom_range(0, 5))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return -16'sd1;
          3: return 16'sd1;
          4: return 16'sd0;
          default: return FIELD_WIDTH'($urandom);
        endcase
      end
      default: return FIELD_WIDTH'($urandom);
    endcase
  endfunction

  task automatic send_random_neuron(input int unsigned length, input value_range_t range);
    for (int unsigned i = 0; i < length; i++) begin
      send_synapse(pick_value(range, 1'b1), pick_value(range, 1'b0), i == length - 1);
    end
  endtask

  function automatic value_range_t pick_range();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return RANGE_SMALL;
    if (roll < 60) return RANGE_MEDIUM;
    if (roll < 85) return RANGE_FULL;
    return RANGE_CORNER;
  endfunction

  task automatic test_directed_cases();
    send_synapse(16'sh7fff, 16'sh7fff, 1'b1);
    send_synapse(16'sh8000, 16'sh8000, 1'b1);
    send_synapse(16'sh8000, 16'sh7fff, 1'b1);
    send_synapse(16'sh7fff, 16'sh8000, 1'b1);
    send_synapse(16'sd0, 16'sd0, 1'b1);
    send_synapse(16'sd1, 16'sd1, 1'b1);
    send_synapse(-16'sd1, 16'sd1, 1'b1);
    send_synapse(16'sd127, 16'sd1, 1'b1);
    send_synapse(16'sd128, 16'sd1, 1'b1);
    send_synapse(-16'sd128, 16'sd1, 1'b1);
    send_synapse(-16'sd129, 16'sd1, 1'b1);
    send_synapse(16'sd256, 16'sd100, 1'b1);
    send_synapse(16'sd256, 16'sd101, 1'b1);
    send_synapse(16'sd256, 16'sd199, 1'b1);
    send_synapse(16'sd256, 16'sd200, 1'b1);
    send_synapse(16'sd256, -16'sd200, 1'b1);
    send_synapse(16'sd1000, 16'sd5, 1'b0);
    send_synapse(-16'sd1000, 16'sd5, 1'b1);
    send_synapse(16'sd5, 16'sd7, 1'b0);
    send_synapse(16'sd300, -16'sd3, 1'b0);
    send_synapse(16'sh7fff, 16'sh7fff, 1'b0);
    send_synapse(16'sd3, 16'sd3, 1'b1);
    wait_for_results();
  endtask

  task automatic test_large_sums();
    gaps_enabled = 1'b0;
    for (int unsigned i = 0; i < LARGE_COUNT; i++) begin
      send_synapse(16'sh8000, 16'sh8000, 1'b0);
    end
    send_synapse(16'sh8000, 16'sh8000, 1'b1);
    for (int unsigned i = 0; i < LARGE_COUNT / 2; i++) begin
      send_synapse(16'sh8000, 16'sh7fff, 1'b0);
    end
    send_synapse(16'sh7fff, 16'sh7fff, 1'b1);
    gaps_enabled = 1'b1;
    wait_for_results();
  endtask

  task automatic test_output_backpressure();
    long_hold_request = 1'b1;
    gaps_enabled      = 1'b0;
    for (int unsigned i = 0; i < 40; i++) begin
      send_random_neuron($urandom_range(1, 2), RANGE_SMALL);
    end
    gaps_enabled = 1'b1;
    wait_for_results();
  endtask

  task automatic test_random_neurons();
    int unsigned first_request;
    int unsigned roll;
    int unsigned length;
    first_request = requests_sent;
    while (requests_sent - first_request < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        length = $urandom_range(1, 6);
      end else if (roll < 95) begin
        length = $urandom_range(7, 24);
      end else begin
        length = $urandom_range(25, 64);
      end
      send_random_neuron(length, pick_range());
    end
    wait_for_results();
  endtask

  initial begin
    error_count         = 0;
    requests_sent       = 0;
    neurons_sent        = 0;
    activations_checked = 0;
    idle_cycles         = 0;
    burst_left          = 0;
    gaps_enabled        = 1'b1;
    long_hold_request   = 1'b0;
    in_if.valid         <= 1'b0;
    in_if.weight        <= '0;
    in_if.in_activation <= '0;
    in_if.last          <= 1'b0;
    rst_n               <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_large_sums();
    test_output_backpressure();
    test_random_neurons();

    while (expected_activations.size() != 0) begin
      report_mismatch("missing out_activation", expected_activations.pop_front(), 0);
    end
    $display("%0d synapse requests over %0d neurons, %0d activations compared",
             requests_sent, neurons_sent, activations_checked);
    $display("rounding and knee edges, extreme product chains, long output hold, random mix");
    if (error_count == 0) begin
      $display("tb_neuron_dot_product_log_limit: PASS");
    end else begin
      $display("tb_neuron_dot_product_log_limit: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/ndp_pkg.sv
rtl/ndp_in_if.sv
rtl/ndp_out_if.sv
rtl/ndp_ctrl.sv
rtl/ndp_datapath.sv
rtl/neuron_dot_product_log_limit.sv
test/tb_neuron_dot_product_log_limit.sv
